// ===== src/wchar_literal_parser_macros.svh =====
// Assertion macros shared by the wide-character literal parser RTL.
`ifndef WCHAR_LITERAL_PARSER_MACROS_SVH
`define WCHAR_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wlp_pkg.sv =====
// Types, codes and character helpers for the wide-character literal parser.
`timescale 1ns / 1ps
package wlp_pkg;

    localparam int CharW  = 8;
    localparam int CodeW  = 16;
    localparam int CountW = 4;
    localparam int PhaseW = 4;

    localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
    localparam logic [PhaseW-1:0] PH_PREFIX    = 4'd1;
    localparam logic [PhaseW-1:0] PH_BODY      = 4'd2;
    localparam logic [PhaseW-1:0] PH_CLOSE_ONE = 4'd3;
    localparam logic [PhaseW-1:0] PH_ESC1      = 4'd4;
    localparam logic [PhaseW-1:0] PH_ESC2      = 4'd5;
    localparam logic [PhaseW-1:0] PH_HEX3      = 4'd6;
    localparam logic [PhaseW-1:0] PH_HEX4      = 4'd7;
    localparam logic [PhaseW-1:0] PH_CLOSE_HEX = 4'd8;

    localparam logic [CharW-1:0] QUOTE_BYTE  = 8'h22;
    localparam logic [CharW-1:0] DOLLAR_BYTE = 8'h24;
    localparam logic [CharW-1:0] W_BYTE      = 8'h57;
    localparam logic [CountW-1:0] PREFIX_LEN = 4'd7;
    localparam logic [CountW-1:0] MAX_POS    = 4'd12;

    typedef struct packed {
        logic              error;
        logic [CountW-1:0] consumed;
        logic [CodeW-1:0]  code_point;
    } wlp_result_t;

    // Expected byte of "WCHAR#" plus opening quote at a given position.
    function automatic logic [CharW-1:0] prefix_char(input logic [CountW-1:0] pos);
        logic [CharW-1:0] c;
        case (pos)
            4'd0:    c = 8'h57; // W
            4'd1:    c = 8'h43; // C
            4'd2:    c = 8'h48; // H
            4'd3:    c = 8'h41; // A
            4'd4:    c = 8'h52; // R
            4'd5:    c = 8'h23; // #
            4'd6:    c = QUOTE_BYTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
        logic [4:0] r;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    // {valid, value}; letters are folded to upper case first
    function automatic logic [8:0] control_value(input logic [CharW-1:0] c);
        logic [CharW-1:0] u;
        logic [8:0]       r;
        u = (c inside {[8'h61:8'h7A]}) ? (c - 8'h20) : c;
        case (u)
            DOLLAR_BYTE: r = {1'b1, 8'h24};
            QUOTE_BYTE:  r = {1'b1, 8'h22};
            8'h4C:       r = {1'b1, 8'h0A}; // L
            8'h4E:       r = {1'b1, 8'h0A}; // N
            8'h50:       r = {1'b1, 8'h0C}; // P
            8'h52:       r = {1'b1, 8'h0D}; // R
            8'h54:       r = {1'b1, 8'h09}; // T
            default:     r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/wlp_in_stage.sv =====
// Input register for incoming character beats.
`timescale 1ns / 1ps
module wlp_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [wlp_pkg::CharW-1:0] s_tdata,
    input  logic                      take,
    output logic                      held_valid,
    output logic [wlp_pkg::CharW-1:0] held_byte
);
    import wlp_pkg::*;

    logic             valid_reg, valid_next;
    logic [CharW-1:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ===== src/wlp_lexer.sv =====
// Literal recognizer: running state and per-byte decode.
`timescale 1ns / 1ps
`include "wchar_literal_parser_macros.svh"
module wlp_lexer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [wlp_pkg::CharW-1:0] char_byte,
    output logic                      res_valid,
    output wlp_pkg::wlp_result_t      res
);
    import wlp_pkg::*;

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [CountW-1:0] pos_reg, pos_next;
    logic [CharW-1:0]  held_reg, held_next;
    logic [CodeW-1:0]  hex_reg, hex_next;

    always_comb
    begin
        logic [4:0]        d1;
        logic [4:0]        d2;
        logic [8:0]        cv;
        logic [CountW-1:0] pos_inc;
        logic              emit;
        logic              fail;
        logic [CodeW-1:0]  value;

        d1      = hex_digit(held_reg);
        d2      = hex_digit(char_byte);
        cv      = control_value(held_reg);
        pos_inc = pos_reg + 4'd1;
        emit    = 1'b0;
        fail    = 1'b0;
        value   = '0;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        hex_next   = hex_reg;

        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (char_byte == QUOTE_BYTE)
                    begin
                        phase_next = PH_BODY;
                        pos_next   = 4'd1;
                    end
                    else if (char_byte == W_BYTE)
                    begin
                        phase_next = PH_PREFIX;
                        pos_next   = 4'd1;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                PH_PREFIX:
                begin
                    if (pos_reg >= PREFIX_LEN || char_byte != prefix_char(pos_reg))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (pos_inc == PREFIX_LEN)
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (char_byte == QUOTE_BYTE)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        held_next  = char_byte;
                        pos_next   = pos_inc;
                        phase_next = (char_byte == DOLLAR_BYTE) ? PH_ESC1 : PH_CLOSE_ONE;
                    end
                end
                PH_CLOSE_ONE:
                begin
                    if (char_byte != QUOTE_BYTE)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        value = {8'd0, held_reg};
                    end
                end
                PH_ESC1:
                begin
                    held_next  = char_byte;
                    pos_next   = pos_inc;
                    phase_next = PH_ESC2;
                end
                PH_ESC2:
                begin
                    // quote here means a single control letter, else two hex digits
                    if (char_byte == QUOTE_BYTE)
                    begin
                        if (!cv[8])
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            emit  = 1'b1;
                            value = {8'd0, cv[7:0]};
                        end
                    end
                    else if (!d1[4] || !d2[4])
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        hex_next   = {8'd0, d1[3:0], d2[3:0]};
                        pos_next   = pos_inc;
                        phase_next = PH_HEX3;
                    end
                end
                PH_HEX3, PH_HEX4:
                begin
                    if (!d2[4])
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        hex_next   = {hex_reg[CodeW-5:0], d2[3:0]};
                        pos_next   = pos_inc;
                        phase_next = (phase_reg == PH_HEX3) ? PH_HEX4 : PH_CLOSE_HEX;
                    end
                end
                PH_CLOSE_HEX:
                begin
                    if (char_byte != QUOTE_BYTE)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        value = hex_reg;
                    end
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase

            if (emit || fail)
            begin
                phase_next = PH_IDLE;
                pos_next   = '0;
                held_next  = '0;
                hex_next   = '0;
            end
        end

        res_valid      = emit || fail;
        res.error      = fail;
        res.consumed   = emit ? pos_inc : '0;
        res.code_point = emit ? value : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            held_reg  <= '0;
            hex_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            hex_reg   <= hex_next;
        end
    end

    `WLP_ASSERT_NOW(a_err_payload_zero, clk, rst_n, res_valid && res.error,
        res.code_point == '0 && res.consumed == '0, "error beat with nonzero payload")
    `WLP_ASSERT_NOW(a_ok_has_count, clk, rst_n, res_valid && !res.error,
        res.consumed >= 4'd2, "good literal shorter than two bytes")
    `WLP_ASSERT_NEXT(a_idle_after_result, clk, rst_n, res_valid,
        phase_reg == PH_IDLE && pos_reg == '0, "not idle after a result")
    `WLP_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1,
        pos_reg <= MAX_POS, "position beyond longest literal")

endmodule

// ===== src/wlp_out_fifo.sv =====
// Two-entry result buffer on the master side.
`timescale 1ns / 1ps
`include "wchar_literal_parser_macros.svh"
module wlp_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wlp_pkg::wlp_result_t push_data,
    output logic                 full,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output wlp_pkg::wlp_result_t pop_data
);
    import wlp_pkg::*;

    wlp_result_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `WLP_ASSERT_NOW(a_no_overflow, clk, rst_n, full, !push, "push into full result buffer")
    `WLP_ASSERT_NOW(a_ptr_count, clk, rst_n, 1'b1,
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg), "pointers disagree with count")

endmodule

// ===== src/wchar_literal_parser.sv =====
// Top level of the wide-character literal parser.
//
// Usage: bytes of literal text arrive one per beat on s_tdata[7:0]. Each
// literal is an optional WCHAR# prefix, a quote, an empty body, one plain
// byte, a $ control letter or $ with four hex digits, and a closing quote.
// The closing quote yields one result beat: m_tdata carries code_point and
// consumed, m_tuser carries error. The first byte that breaks the pattern
// yields a result beat with error set; the following byte starts afresh.
// A result goes from the input register through the decode into the
// result buffer and reaches m_tvalid once stored, behind older results.
// Throughput: one byte per cycle while the result buffer has room; the
// input register, combinational decode and two-entry buffer keep bytes moving.
// Stall: when the receiver holds m_tready low the buffer fills and
// s_tready drops; no beat is lost. s_tready does not depend on m_tready
// combinationally.
// Reset: rst_n clears the parser to idle and empties both stages.
`timescale 1ns / 1ps
module wchar_literal_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] code_point, [19:16] consumed, [23:20] zero
    output logic        m_tuser    // [0] error
);
    import wlp_pkg::*;

    logic             held_valid;
    logic [CharW-1:0] held_byte;
    logic             fifo_full;
    logic             step;
    logic             res_valid;
    wlp_result_t      res;
    wlp_result_t      out_res;

    assign step = held_valid && !fifo_full;

    wlp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wlp_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_byte (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wlp_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (fifo_full),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_res)
    );

    assign m_tdata = {4'd0, out_res.consumed, out_res.code_point};
    assign m_tuser = out_res.error;

endmodule
